>>> hdl/sdae_pkg.sv
package sdae_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam logic [7:0] ASCII_ZERO  = 8'd48;
   localparam logic [7:0] ASCII_MINUS = 8'd45;

   // decimal digits needed for a magnitude of up to 2^(width-1)
   function automatic int digit_count(input int width);
      return ((width - 1) * 30103) / 100000 + 1;
   endfunction

endpackage

>>> hdl/signed_decimal_ascii_emitter.sv
// sequence: accept, then bit-serial double dabble over the magnitude bits, then leading zero
// digits are skipped one at a time, then an optional minus sign and the digits pass through
// the output register, one character per cycle while the receiver is ready
// a new item is accepted only in idle, after the last digit of the previous one entered the output register
// synchronous active-high reset clears the sequencer and the output valid;
// no other state survives an item
module signed_decimal_ascii_emitter
   import sdae_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [VALUE_WIDTH-1:0] value, zero padding above
   input  logic [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] char_code
   output logic [7:0]                        rsp_tdata,
   output logic                              rsp_tlast
);

   localparam int NDIGITS   = digit_count(VALUE_WIDTH);
   localparam int BCD_W     = 4 * NDIGITS;
   localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
   localparam int DIG_CNT_W = $clog2(NDIGITS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CONV,
      S_SKIP,
      S_SIGN,
      S_EMIT
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]   dig_cnt_ff, dig_cnt_in;
   logic                   neg_ff, neg_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_data_ff, out_data_in;
   logic                   out_last_ff, out_last_in;

   logic [VALUE_WIDTH-1:0] raw;
   logic [BCD_W-1:0]       bcd_adj;
   logic [3:0]             top_digit;
   logic                   slot_free;

   assign raw       = req_tdata[VALUE_WIDTH-1:0];
   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign slot_free = !out_valid_ff || rsp_tready;

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int d = 0; d < NDIGITS; d++) begin
         if (bcd_ff[4*d +: 4] >= 4'd5) begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4] + 4'd3;
         end else begin
            bcd_adj[4*d +: 4] = bcd_ff[4*d +: 4];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               neg_in     = raw[VALUE_WIDTH-1];
               // unsigned magnitude, so the most negative value is exact
               mag_in     = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
               bcd_in     = '0;
               bit_cnt_in = BIT_CNT_W'(VALUE_WIDTH - 1);
               dig_cnt_in = DIG_CNT_W'(NDIGITS);
               state_in   = S_CONV;
            end
         end
         S_CONV: begin
            bcd_in = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_WIDTH-1]};
            mag_in = {mag_ff[VALUE_WIDTH-2:0], 1'b0};
            if (bit_cnt_ff == '0) begin
               state_in = S_SKIP;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         S_SKIP: begin
            if (top_digit == 4'd0 && dig_cnt_ff > DIG_CNT_W'(1)) begin
               bcd_in     = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else if (neg_ff) begin
               state_in = S_SIGN;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_SIGN: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_data_in  = ASCII_MINUS;
               out_last_in  = 1'b0;
               state_in     = S_EMIT;
            end
         end
         S_EMIT: begin
            if (slot_free) begin
               out_valid_in = 1'b1;
               out_data_in  = ASCII_ZERO + {4'd0, top_digit};
               out_last_in  = (dig_cnt_ff == DIG_CNT_W'(1));
               bcd_in       = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_cnt_in   = dig_cnt_ff - 1'b1;
               if (dig_cnt_ff == DIG_CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      mag_ff      <= mag_in;
      bcd_ff      <= bcd_in;
      bit_cnt_ff  <= bit_cnt_in;
      dig_cnt_ff  <= dig_cnt_in;
      neg_ff      <= neg_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

`ifndef SYNTHESIS
   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata == ASCII_MINUS ||
                      (rsp_tdata >= ASCII_ZERO && rsp_tdata <= ASCII_ZERO + 8'd9)))
      else $error("character out of range");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata == ASCII_MINUS) |-> !rsp_tlast)
      else $error("minus sign flagged as last");

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_CONV && bcd_ff == '0))
      else $error("accepted item did not start conversion");

   a_emit_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT || state_ff == S_SIGN || state_ff == S_SKIP) |-> dig_cnt_ff != '0)
      else $error("no digit left while emitting");
`endif

endmodule

>>> tb/testbench.sv
module testbench
   import sdae_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VW = VALUE_WIDTH_DEFAULT;
   localparam int DATA_W = ((VW + 7) / 8) * 8;
   localparam int unsigned RADIX = 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 2 * VW + 24;
   localparam int RANDOM_ITEMS = 400;
   localparam int HOLD_AT_CHAR = 60;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last;
   } ascii_char_type;

   class decimal_text_tracker;
      ascii_char_type expected_text[$];
      int             errors = 0;

      // expected characters for one signed value, most significant first
      function void note_value(input logic [VW-1:0] value);
         logic [VW-1:0] mag;
         logic [3:0]    digits[$];
         logic          negative;
         negative = value[VW-1];
         mag = negative ? (~value + 1'b1) : value;
         do begin
            digits.push_front(4'(mag % RADIX));
            mag = mag / RADIX;
         end while (mag != 0);
         if (negative) begin
            expected_text.push_back(ascii_char_type'{char_code: ASCII_MINUS, last: 1'b0});
         end
         for (int i = 0; i < digits.size(); i++) begin
            expected_text.push_back(ascii_char_type'{char_code: ASCII_ZERO + 8'(digits[i]),
                                                     last: (i == digits.size() - 1)});
         end
      endfunction

      function void check_char(input logic [7:0] char_code, input logic last);
         ascii_char_type want;
         if (expected_text.size() == 0) begin
            $display("%0t: unexpected char, expected none, actual %0d last %0b",
                     $time, char_code, last);
            errors++;
            return;
         end
         want = expected_text.pop_front();
         if (char_code !== want.char_code) begin
            $display("%0t: char_code mismatch, expected %0d, actual %0d",
                     $time, want.char_code, char_code);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch, expected %0b, actual %0b", $time, want.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return expected_text.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata = '0;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;
   logic              rsp_tlast;

   decimal_text_tracker tracker = new();
   bit   steady = 1'b0;
   int   cycle_count = 0;

   signed_decimal_ascii_emitter #(.VALUE_WIDTH(VW)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // receiver: checks characters, idles at random outside an always-ready window, one long hold-off
   initial begin
      int chars_seen;
      int hold_left;
      chars_seen = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            tracker.check_char(rsp_tdata, rsp_tlast);
            chars_seen++;
            if (chars_seen == HOLD_AT_CHAR) hold_left = HOLD_CYCLES;
         end
         if (reset) begin
            rsp_tready <= 1'b0;
         end else if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (chars_seen >= 900 && chars_seen < 1500) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 13);
         end
      end
   end

   task automatic send_value(input logic [VW-1:0] value);
      if (!steady) begin
         while ($urandom_range(99) < 13) begin
            req_tvalid <= 1'b0;
            req_tdata <= DATA_W'($urandom);
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= DATA_W'(value);
      do @(posedge clock); while (!req_tready);
      tracker.note_value(value);
   endtask

   function automatic logic [VW-1:0] pick_value();
      longint mag;
      longint pow;
      int     ndig;
      case ($urandom_range(3))
         0: mag = longint'($urandom);
         1: mag = $urandom_range(999);
         2: begin
            pow = 1;
            ndig = $urandom_range(9);
            for (int i = 0; i < ndig; i++) pow = pow * 10;
            mag = pow * $urandom_range(1, 2) + $urandom_range(2) - 1;
         end
         default: begin
            pow = 1;
            ndig = $urandom_range(1, 10);
            for (int i = 1; i < ndig; i++) pow = pow * 10;
            mag = pow + longint'($urandom) % (pow * 9);
         end
      endcase
      if ($urandom_range(1)) mag = -mag;
      return VW'(mag);
   endfunction

   initial begin
      logic [VW-1:0] corner[$];
      corner = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 -32'sd100, 32'd101, 32'd10203, 32'd12345, 32'd1000000000,
                 32'd1000000007, -32'sd1000000000, 32'd2000000000, 32'h7fffffff,
                 32'h80000000, 32'h80000001, 32'd4000000000, -32'sd9, 32'd1000000,
                 32'h55555555, 32'haaaaaaaa};
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (corner[i]) send_value(corner[i]);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 150 && n < 250);
         send_value(pick_value());
      end
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
